@@ rtl/fra_pkg.sv @@
package fra_pkg;

  // operand width default and the fixed result field widths
  localparam int DEF_OPERAND_BITS = 16;
  localparam int NUM_OUT_BITS     = 33;
  localparam int DEN_OUT_BITS     = 32;
  // raw products wrap at this width
  localparam int MAX_RAW_BITS     = 64;

  // operation codes
  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  // result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_ZERO_DEN = 1'b1;

endpackage

@@ rtl/fraction_arith_reduce_top.sv @@
// Flow: the single multiplier forms the raw numerator and denominator (add and subtract take one
//   more step to combine them); unless either raw value is zero, a binary gcd and two
//   bit-serial divisions then reduce them. RAW_W = min(2*OPERAND_BITS+1, 64) (33 by default)
//   is the raw width.
// Sharing: the single multiplier, the shared subtract/compare unit and the one-bit-a-cycle divider
//   serve one word at a time, and a new word is taken only in idle. A new word is taken
//   while a result waits; a finished result holds the sequencer until the previous one is read.
// Reset: synchronous, active high; returns the sequencer to idle and empties the result register.
module fraction_arith_reduce_top
  import fra_pkg::*;
#(
  parameter int OPERAND_BITS = DEF_OPERAND_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [1:0]                     kind,
  input  logic signed [OPERAND_BITS-1:0] a_num,
  input  logic signed [OPERAND_BITS-1:0] a_den,
  input  logic signed [OPERAND_BITS-1:0] b_num,
  input  logic signed [OPERAND_BITS-1:0] b_den,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic signed [NUM_OUT_BITS-1:0] res_num,
  output logic signed [DEN_OUT_BITS-1:0] res_den,
  output logic                           status
);

  localparam int PROD_W = 2 * OPERAND_BITS;
  localparam int RAW_W  = (PROD_W + 1 > MAX_RAW_BITS) ? MAX_RAW_BITS : PROD_W + 1;
  localparam int CNT_W  = $clog2(RAW_W);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M0   = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_GCD  = 4'd6;
  localparam logic [3:0] S_DIVN = 4'd7;
  localparam logic [3:0] S_DIVD = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]                     state;
  logic [1:0]                     op;
  logic signed [OPERAND_BITS-1:0] an, ad, bn, bd;
  logic signed [PROD_W-1:0]       prod;
  logic signed [RAW_W-1:0]        num, den;
  logic                           st;
  logic                           neg_n, neg_d;
  logic [RAW_W-1:0]               u, v, nm, dm;
  logic [RAW_W-1:0]               q, rem;
  logic [CNT_W-1:0]               cnt;

  // shared multiplier operands
  logic signed [OPERAND_BITS-1:0] mx, my;
  logic signed [PROD_W-1:0]       mul_out;
  logic signed [RAW_W-1:0]        prod_ext;
  logic [RAW_W-1:0]               num_mag, den_mag;
  // shared subtract/compare unit
  logic [RAW_W-1:0]               sub_a, sub_b, sub_y;
  logic                           sub_ge;
  logic [RAW_W:0]                 rem_sh;
  logic                           div_ge;
  logic                           addsub;

  assign item_ready = (state == S_IDLE);
  assign addsub     = (op == KIND_ADD) || (op == KIND_SUB);

  always_comb begin
    case (state)
      S_M0: begin
        mx = an;
        my = (op == KIND_MUL) ? bn : bd;
      end
      S_M1: begin
        mx = ad;
        my = (op == KIND_DIV) ? bn : bd;
      end
      default: begin
        mx = ad;
        my = bn;
      end
    endcase
  end

  assign mul_out  = PROD_W'(mx * my);
  assign prod_ext = RAW_W'(prod);
  assign num_mag  = num[RAW_W-1] ? RAW_W'(-num) : RAW_W'(num);
  assign den_mag  = den[RAW_W-1] ? RAW_W'(-den) : RAW_W'(den);

  // one subtractor: gcd difference or trial subtract of the divider
  assign rem_sh = {rem, q[RAW_W-1]};
  always_comb begin
    if (state == S_GCD) begin
      sub_a = (u > v) ? u : v;
      sub_b = (u > v) ? v : u;
    end else begin
      sub_a = rem_sh[RAW_W-1:0];
      sub_b = u;
    end
  end
  assign sub_y  = sub_a - sub_b;
  assign sub_ge = (u > v);
  assign div_ge = (rem_sh >= {1'b0, u});

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // a result loaded in S_OUT takes over the register in the same cycle
      if (res_valid && res_ready && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            op    <= kind;
            an    <= a_num;
            ad    <= a_den;
            bn    <= b_num;
            bd    <= b_den;
            state <= S_M0;
          end
        end
        S_M0: begin
          prod  <= mul_out;
          state <= S_M1;
        end
        S_M1: begin
          num   <= prod_ext;
          prod  <= mul_out;
          state <= S_M2;
        end
        S_M2: begin
          den   <= prod_ext;
          prod  <= mul_out;
          state <= addsub ? S_M3 : S_CHK;
        end
        S_M3: begin
          num   <= (op == KIND_SUB) ? num - prod_ext : num + prod_ext;
          state <= S_CHK;
        end
        S_CHK: begin
          if (den == '0) begin
            st    <= STATUS_ZERO_DEN;
            state <= S_OUT;
          end else if (num == '0) begin
            st    <= STATUS_OK;
            den   <= RAW_W'(1);
            state <= S_OUT;
          end else begin
            st    <= STATUS_OK;
            neg_n <= num[RAW_W-1];
            neg_d <= den[RAW_W-1];
            u     <= num_mag;
            v     <= den_mag;
            nm    <= num_mag;
            dm    <= den_mag;
            state <= S_GCD;
          end
        end
        // binary gcd; common powers of two are stripped from the dividends too
        S_GCD: begin
          if (v == '0) begin
            rem   <= '0;
            q     <= nm;
            cnt   <= '0;
            state <= S_DIVN;
          end else if (!u[0] && !v[0]) begin
            u  <= u >> 1;
            v  <= v >> 1;
            nm <= nm >> 1;
            dm <= dm >> 1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (sub_ge) begin
            u <= sub_y;
          end else begin
            v <= sub_y;
          end
        end
        // restoring division by the odd gcd part, one quotient bit a cycle
        S_DIVN, S_DIVD: begin
          if ((cnt == CNT_W'(RAW_W - 1)) && (state == S_DIVN)) begin
            num   <= neg_n ? -$signed({q[RAW_W-2:0], div_ge})
                           : $signed({q[RAW_W-2:0], div_ge});
            rem   <= '0;
            q     <= dm;
            cnt   <= '0;
            state <= S_DIVD;
          end else begin
            rem <= div_ge ? sub_y : rem_sh[RAW_W-1:0];
            q   <= {q[RAW_W-2:0], div_ge};
            cnt <= cnt + 1'b1;
            if (cnt == CNT_W'(RAW_W - 1)) begin
              den   <= neg_d ? -$signed({q[RAW_W-2:0], div_ge})
                             : $signed({q[RAW_W-2:0], div_ge});
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!res_valid || res_ready) begin
            res_num   <= NUM_OUT_BITS'(num);
            res_den   <= DEN_OUT_BITS'(den);
            status    <= st;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("sequencer did not leave idle after taking a word");

  a_zero_den_raw: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == STATUS_ZERO_DEN) |-> (res_den == '0))
    else $error("zero denominator flagged with non-zero denominator");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_GCD) |-> (u != '0))
    else $error("gcd operand collapsed to zero");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVN) || (state == S_DIVD) |-> (rem < u))
    else $error("divider remainder not below divisor");

endmodule
